// ----- src/mixed_timebase_timestamp_alu_assert.svh -----
// Assertion macros for the mixed-timebase timestamp ALU checker.
// No dependencies; included by the checker file.
`ifndef MIXED_TIMEBASE_TIMESTAMP_ALU_ASSERT_SVH
`define MIXED_TIMEBASE_TIMESTAMP_ALU_ASSERT_SVH

// cond must hold at every clock edge outside reset
`define MTTA_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// ante implies cons in the same cycle
`define MTTA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/mtta_pkg.sv -----
// Shared types and constants for the mixed-timebase timestamp ALU.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtta_pkg;

  localparam int unsigned TICK_W     = 64;
  localparam int unsigned RATE_W     = 31;
  localparam int unsigned FUNC_W     = 4;
  localparam int unsigned DIV_STAGES = TICK_W;
  // register stages from request to result
  localparam int unsigned LATENCY    = 2 + DIV_STAGES + 2 + DIV_STAGES + 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 4'd0,
    FUNC_SUB    = 4'd1,
    FUNC_LT     = 4'd2,
    FUNC_LE     = 4'd3,
    FUNC_EQ     = 4'd4,
    FUNC_REBASE = 4'd5,
    FUNC_FLOOR  = 4'd6,
    FUNC_CEIL   = 4'd7,
    FUNC_ROUND  = 4'd8
  } func_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              same;
    logic [RATE_W-1:0] ra;
    logic [RATE_W-1:0] rb;
    logic [RATE_W-1:0] rt;
    logic [RATE_W-1:0] rr;   // max(ra, rb)
    logic [TICK_W-1:0] a;
    logic [TICK_W-1:0] b;
  } mtta_item_t;

  typedef struct packed {
    mtta_item_t item;
    logic       neg;
  } mtta_split_t;

  typedef struct packed {
    mtta_item_t        item;
    logic [TICK_W-1:0] m;
    logic [RATE_W-1:0] k;
  } mtta_scale_t;

endpackage

`default_nettype wire

// ----- src/mixed_timebase_timestamp_alu.sv -----
// Mixed-timebase timestamp ALU: a fixed-latency pipeline that takes a
// request every cycle (busy is always low) and flags each result on
// done_o, in request order. The latency is set by
// two 64-stage bit-per-stage dividers in series (seconds split, then
// fraction rescale) plus nine register stages of decode, multiply and add.
// The receiver cannot stall; results come out in request order.
// Depends on mtta_pkg and mtta_div.
`timescale 1ns / 1ps
`default_nettype none

module mixed_timebase_timestamp_alu #(
  parameter int unsigned RATE_BITS = 31
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [mtta_pkg::FUNC_W-1:0] func_i,
  input  wire logic [mtta_pkg::TICK_W-1:0] a_ticks_i,
  input  wire logic [mtta_pkg::RATE_W-1:0] a_rate_i,
  input  wire logic [mtta_pkg::TICK_W-1:0] b_ticks_i,
  input  wire logic [mtta_pkg::RATE_W-1:0] b_rate_i,
  input  wire logic [mtta_pkg::RATE_W-1:0] target_rate_i,
  output logic                             done_o,
  output logic [mtta_pkg::TICK_W-1:0]      out_ticks_o,
  output logic [mtta_pkg::RATE_W-1:0]      out_rate_o,
  output logic                             out_flag_o
);
  import mtta_pkg::*;

  localparam logic [RATE_W-1:0] RMASK = RATE_W'((64'd1 << RATE_BITS) - 64'd1);
  localparam int unsigned HALF_W = TICK_W / 2;

  assign busy = 1'b0;

  // ---------------- S0: effective rates, pre-adjust for ceil/round
  logic [RATE_W-1:0] ra_m, rb_m, rt_m, ra_e, rb_e, rt_e;
  logic [TICK_W-1:0] v_d;
  mtta_item_t        s0_item_d, s0_item_q;
  logic [TICK_W-1:0] s0_v_q;
  logic              s0_valid_q;

  assign ra_m = a_rate_i & RMASK;
  assign rb_m = b_rate_i & RMASK;
  assign rt_m = target_rate_i & RMASK;
  assign ra_e = (ra_m == '0) ? RATE_W'(1) : ra_m;
  assign rb_e = (rb_m == '0) ? RATE_W'(1) : rb_m;
  assign rt_e = (rt_m == '0) ? RATE_W'(1) : rt_m;

  always_comb begin
    s0_item_d.func = func_i;
    s0_item_d.same = (ra_e == rb_e);
    s0_item_d.ra   = ra_e;
    s0_item_d.rb   = rb_e;
    s0_item_d.rt   = rt_e;
    s0_item_d.rr   = (ra_e > rb_e) ? ra_e : rb_e;
    s0_item_d.a    = a_ticks_i;
    s0_item_d.b    = b_ticks_i;
    case (func_i)
      FUNC_CEIL:  v_d = a_ticks_i + {{(TICK_W-RATE_W){1'b0}}, ra_e - RATE_W'(1)};
      FUNC_ROUND: v_d = a_ticks_i + {{(TICK_W-RATE_W){1'b0}}, ra_e >> 1};
      default:    v_d = a_ticks_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_item_q <= s0_item_d;
    s0_v_q    <= v_d;
  end

  // ---------------- S1: magnitudes for the unsigned dividers
  logic              s1_valid_q;
  mtta_split_t       s1_split_q;
  logic [TICK_W-1:0] s1_abs_v_q, s1_abs_b_q;
  logic              s1_neg_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_split_q.item <= s0_item_q;
    s1_split_q.neg  <= s0_v_q[TICK_W-1];
    s1_abs_v_q      <= s0_v_q[TICK_W-1] ? -s0_v_q : s0_v_q;
    s1_neg_b_q      <= s0_item_q.b[TICK_W-1];
    s1_abs_b_q      <= s0_item_q.b[TICK_W-1] ? -s0_item_q.b : s0_item_q.b;
  end

  // ---------------- seconds dividers
  logic              da_valid, db_valid;
  logic [TICK_W-1:0] da_q, db_q;
  logic [RATE_W-1:0] da_r, db_r;
  mtta_split_t       da_pl;
  logic              db_neg;

  mtta_div #(.PW($bits(mtta_split_t))) u_div_sec_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s1_valid_q),
    .dividend_i (s1_abs_v_q),
    .divisor_i  (s1_split_q.item.ra),
    .payload_i  (s1_split_q),
    .valid_o    (da_valid),
    .quot_o     (da_q),
    .rem_o      (da_r),
    .payload_o  (da_pl)
  );

  mtta_div #(.PW(1)) u_div_sec_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s1_valid_q),
    .dividend_i (s1_abs_b_q),
    .divisor_i  (s1_split_q.item.rb),
    .payload_i  (s1_neg_b_q),
    .valid_o    (db_valid),
    .quot_o     (db_q),
    .rem_o      (db_r),
    .payload_o  (db_neg)
  );

  // ---------------- D1: floor split and truncated quotient
  logic              d1_valid_q;
  mtta_item_t        d1_item_q;
  logic [TICK_W-1:0] d1_sa_q, d1_sb_q, d1_qt_q;
  logic [RATE_W-1:0] d1_fa_q, d1_fb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_valid_q <= 1'b0;
    end else begin
      d1_valid_q <= da_valid & db_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_item_q <= da_pl.item;
    d1_qt_q   <= da_pl.neg ? -da_q : da_q;
    // negative with remainder: sec = -q - 1 = ~q, frac = r - rem
    if (da_pl.neg && da_r != '0) begin
      d1_sa_q <= ~da_q;
      d1_fa_q <= da_pl.item.ra - da_r;
    end else begin
      d1_sa_q <= da_pl.neg ? -da_q : da_q;
      d1_fa_q <= da_r;
    end
    if (db_neg && db_r != '0) begin
      d1_sb_q <= ~db_q;
      d1_fb_q <= da_pl.item.rb - db_r;
    end else begin
      d1_sb_q <= db_neg ? -db_q : db_q;
      d1_fb_q <= db_r;
    end
  end

  // ---------------- D2: combine seconds, scale fractions
  logic [TICK_W-1:0]   m_d;
  logic [RATE_W-1:0]   k_d, sa_mul, sb_mul;
  logic                bneg_d;
  logic                d2_valid_q;
  mtta_scale_t         d2_scale_q;
  logic [2*RATE_W-1:0] d2_pa_q, d2_pb_q;
  logic                d2_bneg_q;

  always_comb begin
    m_d    = d1_sa_q;
    k_d    = d1_item_q.ra;
    sa_mul = '0;
    sb_mul = '0;
    bneg_d = 1'b0;
    case (d1_item_q.func) inside
      FUNC_ADD: begin
        m_d    = d1_sa_q + d1_sb_q;
        k_d    = d1_item_q.rr;
        sa_mul = d1_item_q.rr;
        sb_mul = d1_item_q.rr;
      end
      FUNC_SUB, FUNC_LT, FUNC_LE, FUNC_EQ: begin
        m_d    = d1_sa_q - d1_sb_q;
        k_d    = d1_item_q.rr;
        sa_mul = d1_item_q.rr;
        sb_mul = d1_item_q.rr;
        bneg_d = 1'b1;
      end
      FUNC_REBASE: begin
        k_d    = d1_item_q.rt;
        sa_mul = d1_item_q.rt;
      end
      FUNC_FLOOR, FUNC_CEIL, FUNC_ROUND: begin
        m_d = d1_qt_q;
      end
      default: begin
        m_d = d1_sa_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d2_valid_q <= 1'b0;
    end else begin
      d2_valid_q <= d1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d2_scale_q.item <= d1_item_q;
    d2_scale_q.m    <= m_d;
    d2_scale_q.k    <= k_d;
    d2_pa_q         <= d1_fa_q * sa_mul;
    d2_pb_q         <= d1_fb_q * sb_mul;
    d2_bneg_q       <= bneg_d;
  end

  // ---------------- fraction dividers
  logic              fa_valid, fb_valid, fb_neg;
  logic [TICK_W-1:0] fa_q, fb_q;
  mtta_scale_t       fa_pl;

  mtta_div #(.PW($bits(mtta_scale_t))) u_div_frac_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (d2_valid_q),
    .dividend_i ({{(TICK_W-2*RATE_W){1'b0}}, d2_pa_q}),
    .divisor_i  (d2_scale_q.item.ra),
    .payload_i  (d2_scale_q),
    .valid_o    (fa_valid),
    .quot_o     (fa_q),
    .rem_o      (),
    .payload_o  (fa_pl)
  );

  mtta_div #(.PW(1)) u_div_frac_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (d2_valid_q),
    .dividend_i ({{(TICK_W-2*RATE_W){1'b0}}, d2_pb_q}),
    .divisor_i  (d2_scale_q.item.rb),
    .payload_i  (d2_bneg_q),
    .valid_o    (fb_valid),
    .quot_o     (fb_q),
    .rem_o      (),
    .payload_o  (fb_neg)
  );

  // ---------------- E1..E4: seconds times rate, plus fractions
  logic                       e1_valid_q, e2_valid_q, e3_valid_q, e4_valid_q;
  mtta_item_t                 e1_item_q, e2_item_q, e3_item_q, e4_item_q;
  logic [HALF_W+RATE_W-1:0]   e1_lo_q;
  logic [HALF_W-1:0]          e1_hi_q;
  logic [TICK_W-1:0]          e1_qa_q, e1_qb_q, e2_qa_q, e2_qb_q, e3_qb_q;
  logic                       e1_bneg_q, e2_bneg_q, e3_bneg_q;
  logic [TICK_W-1:0]          e2_prod_q, e3_t_q, e4_d_q;
  logic [HALF_W+RATE_W-1:0]   hi_full;

  assign hi_full = fa_pl.m[TICK_W-1:HALF_W] * fa_pl.k;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_valid_q <= 1'b0;
      e2_valid_q <= 1'b0;
      e3_valid_q <= 1'b0;
      e4_valid_q <= 1'b0;
    end else begin
      e1_valid_q <= fa_valid & fb_valid;
      e2_valid_q <= e1_valid_q;
      e3_valid_q <= e2_valid_q;
      e4_valid_q <= e3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e1_item_q <= fa_pl.item;
    e1_lo_q   <= fa_pl.m[HALF_W-1:0] * fa_pl.k;
    e1_hi_q   <= hi_full[HALF_W-1:0];
    e1_qa_q   <= fa_q;
    e1_qb_q   <= fb_q;
    e1_bneg_q <= fb_neg;

    e2_item_q <= e1_item_q;
    e2_prod_q <= {{(TICK_W-HALF_W-RATE_W){1'b0}}, e1_lo_q} + {e1_hi_q, {HALF_W{1'b0}}};
    e2_qa_q   <= e1_qa_q;
    e2_qb_q   <= e1_qb_q;
    e2_bneg_q <= e1_bneg_q;

    e3_item_q <= e2_item_q;
    e3_t_q    <= e2_prod_q + e2_qa_q;
    e3_qb_q   <= e2_qb_q;
    e3_bneg_q <= e2_bneg_q;

    e4_item_q <= e3_item_q;
    e4_d_q    <= e3_bneg_q ? e3_t_q - e3_qb_q : e3_t_q + e3_qb_q;
  end

  // ---------------- E5: final select, output register
  logic [TICK_W-1:0] ticks_d, neg_d;
  logic [RATE_W-1:0] rate_d;
  logic              flag_d;
  logic              out_valid_q;
  logic [TICK_W-1:0] out_ticks_q;
  logic [RATE_W-1:0] out_rate_q;
  logic              out_flag_q;

  assign neg_d = -e4_d_q;

  always_comb begin
    ticks_d = e4_item_q.a;
    rate_d  = e4_item_q.ra;
    flag_d  = 1'b0;
    case (e4_item_q.func) inside
      FUNC_ADD: begin
        ticks_d = e4_item_q.same ? e4_item_q.a + e4_item_q.b : e4_d_q;
        rate_d  = e4_item_q.rr;
      end
      FUNC_SUB: begin
        ticks_d = e4_item_q.same ? e4_item_q.a - e4_item_q.b : e4_d_q;
        rate_d  = e4_item_q.rr;
      end
      FUNC_LT: begin
        ticks_d = '0;
        flag_d  = e4_item_q.same ? ($signed(e4_item_q.a) < $signed(e4_item_q.b))
                                 : e4_d_q[TICK_W-1];
      end
      FUNC_LE: begin
        ticks_d = '0;
        flag_d  = e4_item_q.same ? ($signed(e4_item_q.a) <= $signed(e4_item_q.b))
                                 : ~neg_d[TICK_W-1];
      end
      FUNC_EQ: begin
        ticks_d = '0;
        flag_d  = e4_item_q.same ? (e4_item_q.a == e4_item_q.b) : (e4_d_q == '0);
      end
      FUNC_REBASE: begin
        ticks_d = e4_d_q;
        rate_d  = e4_item_q.rt;
      end
      FUNC_FLOOR, FUNC_CEIL, FUNC_ROUND: begin
        ticks_d = e4_d_q;
      end
      default: begin
        ticks_d = e4_item_q.a;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= e4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ticks_q <= ticks_d;
    out_rate_q  <= rate_d;
    out_flag_q  <= flag_d;
  end

  assign done_o      = out_valid_q;
  assign out_ticks_o = out_ticks_q;
  assign out_rate_o  = out_rate_q;
  assign out_flag_o  = out_flag_q;

endmodule

`default_nettype wire

// ----- src/mtta_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on mtta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtta_div #(
  parameter int unsigned PW = 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  input  wire logic [mtta_pkg::TICK_W-1:0] dividend_i,
  input  wire logic [mtta_pkg::RATE_W-1:0] divisor_i,
  input  wire logic [PW-1:0]              payload_i,
  output logic                            valid_o,
  output logic [mtta_pkg::TICK_W-1:0]     quot_o,
  output logic [mtta_pkg::RATE_W-1:0]     rem_o,
  output logic [PW-1:0]                   payload_o
);
  import mtta_pkg::*;

  logic              v_q   [DIV_STAGES];
  logic [TICK_W-1:0] dq_q  [DIV_STAGES];
  logic [RATE_W-1:0] rem_q [DIV_STAGES];
  logic [RATE_W-1:0] dv_q  [DIV_STAGES];
  logic [PW-1:0]     pl_q  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic              v_in;
    logic [TICK_W-1:0] dq_in;
    logic [RATE_W-1:0] rem_in;
    logic [RATE_W-1:0] dv_in;
    logic [PW-1:0]     pl_in;
    logic [RATE_W:0]   trial;
    logic              ge;
    logic [RATE_W:0]   diff;
    logic [TICK_W-1:0] dq_d;
    logic [RATE_W-1:0] rem_d;

    if (s == 0) begin : g_first
      assign v_in   = valid_i;
      assign dq_in  = dividend_i;
      assign rem_in = '0;
      assign dv_in  = divisor_i;
      assign pl_in  = payload_i;
    end else begin : g_next
      assign v_in   = v_q[s-1];
      assign dq_in  = dq_q[s-1];
      assign rem_in = rem_q[s-1];
      assign dv_in  = dv_q[s-1];
      assign pl_in  = pl_q[s-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign trial = {rem_in, dq_in[TICK_W-1]};
    assign diff  = trial - {1'b0, dv_in};
    assign ge    = (trial >= {1'b0, dv_in});
    assign rem_d = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
    assign dq_d  = {dq_in[TICK_W-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dq_q[s]  <= dq_d;
      rem_q[s] <= rem_d;
      dv_q[s]  <= dv_in;
      pl_q[s]  <= pl_in;
    end
  end

  assign valid_o   = v_q[DIV_STAGES-1];
  assign quot_o    = dq_q[DIV_STAGES-1];
  assign rem_o     = rem_q[DIV_STAGES-1];
  assign payload_o = pl_q[DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- src/mtta_checker.sv -----
// Port-level checks for the mixed-timebase timestamp ALU, bound to the top.
// Depends on mtta_pkg and mixed_timebase_timestamp_alu_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "mixed_timebase_timestamp_alu_assert.svh"

module mtta_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done_o,
  input wire logic [mtta_pkg::TICK_W-1:0] out_ticks_o,
  input wire logic [mtta_pkg::RATE_W-1:0] out_rate_o,
  input wire logic                        out_flag_o
);
  import mtta_pkg::*;

  // every result traces back to a request a fixed number of cycles earlier
  `MTTA_ASSERT_IMPLY(a_fixed_latency, clk_i, rst_ni, done_o, $past(start && !busy, LATENCY))
  `MTTA_ASSERT_ALWAYS(a_never_busy, clk_i, rst_ni, !busy)
  `MTTA_ASSERT_IMPLY(a_rate_nonzero, clk_i, rst_ni, done_o, out_rate_o != '0)
  `MTTA_ASSERT_IMPLY(a_flag_zero_ticks, clk_i, rst_ni, done_o && out_flag_o, out_ticks_o == '0)

endmodule

bind mixed_timebase_timestamp_alu mtta_checker u_mtta_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .out_ticks_o (out_ticks_o),
  .out_rate_o  (out_rate_o),
  .out_flag_o  (out_flag_o)
);

`default_nettype wire
